/* rtl/threshold_to_escpos_bit_image_defines.svh */
// ----------------------------------------------------------------------------
// Threshold to ESC/POS bit image - assertion macros
// Shared property macros, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_TO_ESCPOS_BIT_IMAGE_DEFINES_SVH
`define THRESHOLD_TO_ESCPOS_BIT_IMAGE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TEBI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TEBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tebi_pkg.sv */
// ----------------------------------------------------------------------------
// tebi_pkg
// Types, constants and byte table of the ESC/POS bit image encoder.
// ----------------------------------------------------------------------------
package tebi_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STRIPE_ROWS = 24;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SROW_W      = $clog2(STRIPE_ROWS);
  localparam int STORE_W     = STRIPE_ROWS - 1;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int THR_W       = 9;
  localparam int CFG_DATA_W  = 13;
  localparam int LUM_W       = 16;
  localparam int NUM_SLOTS   = 14;
  localparam int SLOT_W      = 4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_t;

  // Byte slots of the output sequence for one pixel
  localparam logic [SLOT_W-1:0] SLOT_PRO0 = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_PRO1 = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_PRO2 = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_HDR0 = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_HDR1 = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_HDR2 = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_WLO  = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_WHI  = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_COL0 = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_COL1 = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_COL2 = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_EOL  = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_FIN0 = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_FIN1 = 4'd13;

  // Command bytes
  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_SPACING = 8'h33;
  localparam logic [7:0] BYTE_DOTS24  = 8'd24;
  localparam logic [7:0] BYTE_IMAGE   = 8'h2A;
  localparam logic [7:0] BYTE_MODE33  = 8'd33;
  localparam logic [7:0] BYTE_LF      = 8'h0A;

  // Classified pixel, one per accepted transaction
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [SROW_W-1:0]  srow;
    logic               dot;
    logic               prologue;
    logic               sending;
    logic               header;
    logic               eol;
    logic               fin;
    logic [WIDTH_W-1:0] width;
  } pix_t;

  // Work handed to the byte sequencer
  typedef struct packed {
    logic [NUM_SLOTS-1:0]   mask;
    logic [STRIPE_ROWS-1:0] bits;
    logic [WIDTH_W-1:0]     width;
  } desc_t;

  // Column byte: top row of the group lands in bit 7
  function automatic logic [7:0] col_byte(input logic [7:0] grp);
    logic [7:0] res;
    for (int j = 0; j < 8; j++) res[7-j] = grp[j];
    return res;
  endfunction

  function automatic logic [7:0] slot_byte(input logic [SLOT_W-1:0]      slot,
                                           input logic [STRIPE_ROWS-1:0] bits,
                                           input logic [WIDTH_W-1:0]     width);
    logic [7:0] res;
    unique case (slot)
      SLOT_PRO0: res = BYTE_ESC;
      SLOT_PRO1: res = BYTE_SPACING;
      SLOT_PRO2: res = BYTE_DOTS24;
      SLOT_HDR0: res = BYTE_ESC;
      SLOT_HDR1: res = BYTE_IMAGE;
      SLOT_HDR2: res = BYTE_MODE33;
      SLOT_WLO:  res = width[7:0];
      SLOT_WHI:  res = {{(16-WIDTH_W){1'b0}}, width[WIDTH_W-1:8]};
      SLOT_COL0: res = col_byte(bits[7:0]);
      SLOT_COL1: res = col_byte(bits[15:8]);
      SLOT_COL2: res = col_byte(bits[23:16]);
      SLOT_EOL:  res = BYTE_LF;
      SLOT_FIN0: res = BYTE_LF;
      SLOT_FIN1: res = BYTE_LF;
      default:   res = BYTE_LF;
    endcase
    return res;
  endfunction

endpackage

/* rtl/tebi_intf.sv */
// ----------------------------------------------------------------------------
// tebi_pixel_if / tebi_byte_if
// Valid/ready channels for RGB pixels in and command bytes out.
// ----------------------------------------------------------------------------
interface tebi_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface tebi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       image_end;

  modport source (output valid, output out_byte, output run_end, output image_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input image_end,
                  output ready);
endinterface

/* rtl/threshold_to_escpos_bit_image.sv */
// ----------------------------------------------------------------------------
// threshold_to_escpos_bit_image
// RGB pixel stream to ESC/POS 24-dot double-density bit image commands.
//
//   channel  | dir | transaction
//   ---------+-----+---------------------------------------------------
//   in_ch    | in  | one RGB pixel, row-major
//   out_ch   | out | one command byte, run_end / image_end flags
//   cfg_*    | in  | register write: width, height, threshold
//
// A pixel that sends nothing retires without waiting on the sequencer, back to back.
// A sending pixel drains 3 to 14 bytes from the sequencer at one byte a cycle
// while out_ch is ready; the next pixel is accepted while those bytes drain and
// waits in the stripe stage only when it has bytes of its own to send.
// The stripe memory is read on accept and written back on retire, in the cycle
// after accept at the earliest; a bypass register covers the same column twice in a row.
// Reset clears counters and valid state; stripe memory needs no clearing.
// ----------------------------------------------------------------------------
module threshold_to_escpos_bit_image
  import tebi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tebi_pixel_if.sink            in_ch,
  tebi_byte_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [THR_W-1:0]    dark_threshold_r;
  pix_t                pix;
  desc_t               desc;
  logic                desc_valid;
  logic                desc_ready;
  logic                in_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= WIDTH_W'(384);
      image_height_r   <= HEIGHT_W'(24);
      dark_threshold_r <= THR_W'(127);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  image_width_r    <= cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT: image_height_r   <= cfg_data[HEIGHT_W-1:0];
        CFG_THRESH: dark_threshold_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  tebi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .image_width    (image_width_r),
    .image_height   (image_height_r),
    .dark_threshold (dark_threshold_r),
    .red            (in_ch.red),
    .green          (in_ch.green),
    .blue           (in_ch.blue),
    .accept         (in_fire),
    .pix            (pix)
  );

  tebi_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_pix   (pix),
    .a_fire  (in_fire),
    .a_ready (in_ch.ready),
    .d       (desc),
    .d_valid (desc_valid),
    .d_ready (desc_ready)
  );

  tebi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .d         (desc),
    .d_valid   (desc_valid),
    .d_ready   (desc_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_end   (out_ch.run_end),
    .image_end (out_ch.image_end)
  );

endmodule

/* rtl/tebi_front.sv */
// ----------------------------------------------------------------------------
// tebi_front
// Pixel classifier: luminance threshold and image position counters.
// ----------------------------------------------------------------------------
module tebi_front
  import tebi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WIDTH_W-1:0]  image_width,
  input  logic [HEIGHT_W-1:0] image_height,
  input  logic [THR_W-1:0]    dark_threshold,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic                accept,
  output pix_t                pix
);

  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [SROW_W-1:0]   srow_r, srow_nxt;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [LUM_W-1:0]    lum;
  logic [LUM_W-1:0]    lum_limit;
  logic                last_col;
  logic                last_row;

  // Clamp the configured sizes into range
  always_comb begin
    if (image_width == '0)                            w_eff = WIDTH_W'(1);
    else if (image_width > WIDTH_W'(MAX_WIDTH))       w_eff = WIDTH_W'(MAX_WIDTH);
    else                                              w_eff = image_width;
    if (image_height == '0)                           h_eff = HEIGHT_W'(1);
    else if (image_height > HEIGHT_W'(MAX_HEIGHT))    h_eff = HEIGHT_W'(MAX_HEIGHT);
    else                                              h_eff = image_height;
  end

  // 30r + 59g + 11b against 100 x threshold, exact
  assign lum = LUM_W'(LUM_W'(red) * LUM_W'(30)) + LUM_W'(LUM_W'(green) * LUM_W'(59))
             + LUM_W'(LUM_W'(blue) * LUM_W'(11));
  assign lum_limit = LUM_W'(LUM_W'(dark_threshold) * LUM_W'(100));

  assign last_col = (WIDTH_W'(col_cnt_r) + WIDTH_W'(1)) >= w_eff;
  assign last_row = (HEIGHT_W'(row_cnt_r) + HEIGHT_W'(1)) >= h_eff;

  // Classification of the pixel at the head of the input
  always_comb begin
    pix.col      = col_cnt_r;
    pix.srow     = srow_r;
    pix.dot      = lum < lum_limit;
    pix.prologue = (col_cnt_r == '0) && (row_cnt_r == '0);
    pix.sending  = (srow_r == SROW_W'(STRIPE_ROWS - 1)) || last_row;
    pix.header   = pix.sending && (col_cnt_r == '0);
    pix.eol      = pix.sending && last_col;
    pix.fin      = pix.sending && last_col && last_row;
    pix.width    = w_eff;
  end

  // Position update
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    srow_nxt    = srow_r;
    if (accept) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        if (last_row) begin
          row_cnt_nxt = '0;
          srow_nxt    = '0;
        end else begin
          row_cnt_nxt = row_cnt_r + ROW_W'(1);
          srow_nxt    = (srow_r == SROW_W'(STRIPE_ROWS - 1)) ? '0 : srow_r + SROW_W'(1);
        end
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      srow_r    <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      srow_r    <= srow_nxt;
    end
  end

endmodule

/* rtl/tebi_store.sv */
// ----------------------------------------------------------------------------
// tebi_store
// Stripe memory with read-modify-write per column and write forwarding.
// ----------------------------------------------------------------------------
module tebi_store
  import tebi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  pix_t  a_pix,
  input  logic  a_fire,
  output logic  a_ready,
  output desc_t d,
  output logic  d_valid,
  input  logic  d_ready
);

  logic [STORE_W-1:0]     mem [MAX_WIDTH];
  logic [STORE_W-1:0]     rdata_r;
  logic                   b_vld_r;
  pix_t                   b_pix_r;
  logic                   fwd_vld_r;
  logic [COL_W-1:0]       fwd_addr_r;
  logic [STORE_W-1:0]     fwd_data_r;
  logic [STORE_W-1:0]     stored;
  logic [STRIPE_ROWS-1:0] keep_mask;
  logic [STRIPE_ROWS-1:0] bits;
  logic                   wr_en;
  logic                   b_fire;

  // Last write may land on the edge of the read: take it from the bypass
  assign stored = (fwd_vld_r && (fwd_addr_r == b_pix_r.col)) ? fwd_data_r : rdata_r;

  // Merge rows above this one with the new dot
  assign keep_mask = (STRIPE_ROWS'(1) << b_pix_r.srow) - STRIPE_ROWS'(1);
  assign bits = ({1'b0, stored} & keep_mask) | (STRIPE_ROWS'(b_pix_r.dot) << b_pix_r.srow);
  assign wr_en = b_pix_r.srow != SROW_W'(STRIPE_ROWS - 1);

  // Byte work for the sequencer
  always_comb begin
    d.mask            = '0;
    d.mask[SLOT_PRO0] = b_pix_r.prologue;
    d.mask[SLOT_PRO1] = b_pix_r.prologue;
    d.mask[SLOT_PRO2] = b_pix_r.prologue;
    d.mask[SLOT_HDR0] = b_pix_r.header;
    d.mask[SLOT_HDR1] = b_pix_r.header;
    d.mask[SLOT_HDR2] = b_pix_r.header;
    d.mask[SLOT_WLO]  = b_pix_r.header;
    d.mask[SLOT_WHI]  = b_pix_r.header;
    d.mask[SLOT_COL0] = b_pix_r.sending;
    d.mask[SLOT_COL1] = b_pix_r.sending;
    d.mask[SLOT_COL2] = b_pix_r.sending;
    d.mask[SLOT_EOL]  = b_pix_r.eol;
    d.mask[SLOT_FIN0] = b_pix_r.fin;
    d.mask[SLOT_FIN1] = b_pix_r.fin;
    d.bits            = bits;
    d.width           = b_pix_r.width;
  end

  // Silent pixels retire without waiting on the sequencer
  assign d_valid = b_vld_r && (d.mask != '0);
  assign b_fire  = b_vld_r && ((d.mask == '0) || d_ready);
  assign a_ready = !b_vld_r || b_fire;

  // Stripe memory: read on accept, write back on retire
  always_ff @(posedge clk) begin
    if (a_fire) rdata_r <= mem[a_pix.col];
    if (b_fire && wr_en) mem[b_pix_r.col] <= bits[STORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (a_fire) b_pix_r <= a_pix;
    if (b_fire && wr_en) begin
      fwd_addr_r <= b_pix_r.col;
      fwd_data_r <= bits[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (a_fire)      b_vld_r <= 1'b1;
      else if (b_fire) b_vld_r <= 1'b0;
      if (b_fire && wr_en) fwd_vld_r <= 1'b1;
    end
  end

endmodule

/* rtl/tebi_seq.sv */
// ----------------------------------------------------------------------------
// tebi_seq
// Byte sequencer: sends the pending slots of one pixel, one byte a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tebi_seq
  import tebi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      d,
  input  logic       d_valid,
  output logic       d_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       image_end
);

  logic [NUM_SLOTS-1:0]   mask_r, mask_nxt;
  logic [STRIPE_ROWS-1:0] bits_r;
  logic [WIDTH_W-1:0]     width_r;
  logic [SLOT_W-1:0]      slot;
  logic [NUM_SLOTS-1:0]   slot_bit;
  logic                   load;

  // Lowest pending slot goes next
  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) slot = SLOT_W'(i);
    end
  end

  assign slot_bit  = NUM_SLOTS'(1) << slot;
  assign out_valid = mask_r != '0;
  assign run_end   = (mask_r & ~slot_bit) == '0;
  assign image_end = slot == SLOT_FIN1;
  assign out_byte  = slot_byte(slot, bits_r, width_r);

  // Take new work when empty or when the last byte leaves now
  assign d_ready = !out_valid || (out_ready && run_end);
  assign load    = d_valid && d_ready;

  always_comb begin
    mask_nxt = mask_r;
    if (out_valid && out_ready) mask_nxt = mask_r & ~slot_bit;
    if (load)                   mask_nxt = d.mask;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits_r  <= d.bits;
      width_r <= d.width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '0;
    else        mask_r <= mask_nxt;
  end

endmodule

/* rtl/tebi_checker.sv */
// ----------------------------------------------------------------------------
// tebi_checker
// Port-level checks on the command byte stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "threshold_to_escpos_bit_image_defines.svh"

module tebi_checker
  import tebi_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       image_end
);

  // A stalled byte stays offered
  `TEBI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")

  // Image end is a line feed that also closes its pixel's bytes
  `TEBI_ASSERT_SAME(a_end_lf, out_valid && image_end, run_end && (out_byte == BYTE_LF), "bad image end byte")

  // Bytes of one pixel follow each other without a gap
  `TEBI_ASSERT_NEXT(a_run_gapless, out_valid && out_ready && !run_end, out_valid, "gap inside a pixel's bytes")

  // A new image opens with ESC
  `TEBI_ASSERT_NEXT(a_new_image, out_valid && out_ready && image_end, !out_valid || (out_byte == BYTE_ESC), "new image does not start with ESC")

endmodule

bind threshold_to_escpos_bit_image tebi_checker u_tebi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_end   (out_ch.run_end),
  .image_end (out_ch.image_end)
);
